// ===== src/first_fit_region_allocator_top_macros.svh =====
// Assertion macros for the first-fit region allocator.
// Used by the top level only; depends on nothing.
`ifndef FIRST_FIT_REGION_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_REGION_ALLOCATOR_TOP_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define FFRA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define FFRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ffra_pkg.sv =====
// Shared types and constants of the first-fit region allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package ffra_pkg;

   localparam int unsigned MAX_ENTRIES_DEFAULT = 16;
   localparam logic [31:0] REGION_RESET        = 32'd1048576;
   localparam int unsigned REQ_DATA_W          = 64;
   localparam int unsigned RSP_DATA_W          = 232;

   typedef enum logic [1:0] {
      MODE_ALLOC   = 2'd0,
      MODE_FREE    = 2'd1,
      MODE_REALLOC = 2'd2,
      MODE_RESOLVE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_SIZE   = 3'd1,
      ST_NO_MEM     = 3'd2,
      ST_BAD_HANDLE = 3'd3,
      ST_TABLE_FULL = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      KIND_FINAL,
      KIND_PACK,
      KIND_RELOC
   } kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_FIND,
      S_RESIZE,
      S_BOUND,
      S_HOLE,
      S_PACK,
      S_RELOC,
      S_REMOVE,
      S_INSERT,
      S_FINAL
   } state_type;

   typedef struct packed {
      logic       load;
      logic       ptr_clr;
      logic       ptr_inc;
      logic       ptr_idx;
      logic       ptr_after_idx;
      logic       take_idx;
      logic       oout_rd;
      logic       oout_idx;
      logic       set_st;
      status_type st;
      logic       sub_used;
      logic       resize;
      logic       commit_alloc;
      logic       commit_realloc;
      logic       cur_clr;
      logic       cur_hole;
      logic       cur_pack;
      logic       where_cur;
      logic       where_base;
      logic       pack_wr;
      logic       remove;
      logic       insert;
      logic       out_load;
      kind_type   kind;
   } dp_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     ptr_end;
      logic     id_hit;
      logic     size_zero;
      logic     size_gt_free;
      logic     full;
      logic     shrink;
      logic     room_ok;
      logic     hole_fit;
      logic     tail_fit;
      logic     off_differs;
      logic     ins_here;
      logic     out_free;
   } dp_sts_type;

endpackage

// ===== src/ffra_ctrl.sv =====
// Controller state machine of the first-fit region allocator.
// Depends on ffra_pkg; drives the datapath ffra_dp through command signals.
module ffra_ctrl
   import ffra_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.st     = ST_OK;
      cmd.kind   = KIND_FINAL;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.mode)
               MODE_ALLOC: begin
                  cmd.set_st = 1'b1;
                  state_in   = S_FINAL;
                  if (sts.size_zero) begin
                     cmd.st = ST_BAD_SIZE;
                  end else if (sts.size_gt_free) begin
                     cmd.st = ST_NO_MEM;
                  end else if (sts.full) begin
                     cmd.st = ST_TABLE_FULL;
                  end else begin
                     cmd.set_st       = 1'b0;
                     cmd.commit_alloc = 1'b1;
                     cmd.ptr_clr      = 1'b1;
                     cmd.cur_clr      = 1'b1;
                     state_in         = S_HOLE;
                  end
               end
               MODE_REALLOC: begin
                  if (sts.size_zero) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = ST_BAD_SIZE;
                     state_in   = S_FINAL;
                  end else begin
                     state_in = S_FIND;
                  end
               end
               default: begin
                  state_in = S_FIND;
               end
            endcase
         end
         S_FIND: begin
            if (sts.ptr_end) begin
               cmd.set_st = 1'b1;
               cmd.st     = ST_BAD_HANDLE;
               state_in   = S_FINAL;
            end else if (sts.id_hit) begin
               cmd.take_idx = 1'b1;
               case (sts.mode)
                  MODE_RESOLVE: begin
                     cmd.oout_rd = 1'b1;
                     state_in    = S_FINAL;
                  end
                  MODE_FREE: begin
                     cmd.oout_rd  = 1'b1;
                     cmd.sub_used = 1'b1;
                     state_in     = S_REMOVE;
                  end
                  default: begin
                     state_in = S_RESIZE;
                  end
               endcase
            end else begin
               cmd.ptr_inc = 1'b1;
            end
         end
         S_RESIZE: begin
            if (sts.shrink) begin
               cmd.resize   = 1'b1;
               cmd.oout_idx = 1'b1;
               state_in     = S_FINAL;
            end else begin
               cmd.ptr_after_idx = 1'b1;
               state_in          = S_BOUND;
            end
         end
         S_BOUND: begin
            if (sts.room_ok) begin
               cmd.resize   = 1'b1;
               cmd.oout_idx = 1'b1;
               state_in     = S_FINAL;
            end else if (sts.size_gt_free) begin
               cmd.set_st = 1'b1;
               cmd.st     = ST_NO_MEM;
               state_in   = S_FINAL;
            end else begin
               cmd.commit_realloc = 1'b1;
               cmd.ptr_clr        = 1'b1;
               cmd.cur_clr        = 1'b1;
               state_in           = S_HOLE;
            end
         end
         S_HOLE: begin
            if ((!sts.ptr_end && sts.hole_fit) || (sts.ptr_end && sts.tail_fit)) begin
               cmd.where_cur = 1'b1;
               if (sts.mode == MODE_ALLOC) begin
                  cmd.ptr_clr = 1'b1;
                  state_in    = S_INSERT;
               end else begin
                  cmd.ptr_idx = 1'b1;
                  state_in    = S_RELOC;
               end
            end else if (!sts.ptr_end) begin
               cmd.cur_hole = 1'b1;
               cmd.ptr_inc  = 1'b1;
            end else begin
               cmd.ptr_clr = 1'b1;
               cmd.cur_clr = 1'b1;
               state_in    = S_PACK;
            end
         end
         S_PACK: begin
            if (sts.ptr_end) begin
               cmd.where_base = 1'b1;
               if (sts.mode == MODE_ALLOC) begin
                  cmd.ptr_clr = 1'b1;
                  state_in    = S_INSERT;
               end else begin
                  cmd.ptr_idx = 1'b1;
                  state_in    = S_RELOC;
               end
            end else if (!sts.off_differs) begin
               cmd.cur_pack = 1'b1;
               cmd.ptr_inc  = 1'b1;
            end else if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.kind     = KIND_PACK;
               cmd.pack_wr  = 1'b1;
               cmd.cur_pack = 1'b1;
               cmd.ptr_inc  = 1'b1;
            end
         end
         S_RELOC: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.kind     = KIND_RELOC;
               state_in     = S_REMOVE;
            end
         end
         S_REMOVE: begin
            cmd.remove  = 1'b1;
            cmd.ptr_clr = 1'b1;
            if (sts.mode == MODE_FREE) begin
               state_in = S_FINAL;
            end else begin
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            if (sts.ins_here) begin
               cmd.insert = 1'b1;
               state_in   = S_FINAL;
            end else begin
               cmd.ptr_inc = 1'b1;
            end
         end
         S_FINAL: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.kind     = KIND_FINAL;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== src/ffra_dp.sv =====
// Datapath of the first-fit region allocator: entry table, totals, scan and result register.
// Depends on ffra_pkg; steered by the controller ffra_ctrl.
module ffra_dp
   import ffra_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  csr_valid,
   input  logic [31:0]           csr_data,
   input  dp_cmd_type            cmd,
   output dp_sts_type            sts,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [2:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   logic [31:0] ids_ff  [MAX_ENTRIES];
   logic [31:0] offs_ff [MAX_ENTRIES];
   logic [31:0] sizes_ff[MAX_ENTRIES];

   mode_type    mode_ff;
   logic [31:0] hid_ff, size_ff;
   status_type  st_ff;
   logic [31:0] hout_ff, oout_ff, old_ff, idx_off_ff, where_ff, base_ff;
   logic [32:0] end_ff, cur_ff;
   logic [CW-1:0] ptr_ff, idx_ff, count_ff;
   logic        pend_ff;
   logic [31:0] used_ff, alloc_ff, next_ff, region_ff;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [2:0]            rsp_user_ff;
   logic                  rsp_last_ff;

   logic [31:0] id_rd, off_rd, size_rd, free_c, bound_c, new_used_c;
   logic [32:0] off_ext, size_ext;
   logic [CW-1:0] live_c;
   logic [IW-1:0] ptr_ix, idx_ix;
   logic        out_free_c;

   assign ptr_ix  = ptr_ff[IW-1:0];
   assign idx_ix  = idx_ff[IW-1:0];
   assign id_rd   = ids_ff[ptr_ix];
   assign off_rd  = offs_ff[ptr_ix];
   assign size_rd = sizes_ff[ptr_ix];
   assign off_ext  = {1'b0, off_rd};
   assign size_ext = {1'b0, size_ff};
   assign free_c  = (region_ff > used_ff) ? (region_ff - used_ff) : 32'd0;
   assign bound_c = (ptr_ff < count_ff) ? off_rd : region_ff;
   assign new_used_c = used_ff + size_ff - old_ff;
   assign live_c  = count_ff + {{(CW-1){1'b0}}, pend_ff};
   assign out_free_c = !rsp_valid_ff || rsp_tready;

   always_comb begin
      sts              = '0;
      sts.mode         = mode_ff;
      sts.ptr_end      = (ptr_ff >= count_ff);
      sts.id_hit       = (id_rd == hid_ff);
      sts.size_zero    = (size_ff == 32'd0);
      sts.size_gt_free = (size_ff > free_c);
      sts.full         = (count_ff >= CW'(MAX_ENTRIES));
      sts.shrink       = (size_ff <= old_ff);
      sts.room_ok      = ({1'b0, bound_c} >= end_ff)
                         && (({1'b0, bound_c} - end_ff) >= {1'b0, size_ff - old_ff});
      sts.hole_fit     = (off_ext >= cur_ff) && ((off_ext - cur_ff) >= size_ext);
      sts.tail_fit     = ({1'b0, region_ff} >= cur_ff)
                         && (({1'b0, region_ff} - cur_ff) >= size_ext);
      sts.off_differs  = (off_rd != cur_ff[31:0]);
      sts.ins_here     = (ptr_ff >= count_ff) || (off_rd > where_ff);
      sts.out_free     = out_free_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         pend_ff   <= 1'b0;
         used_ff   <= '0;
         alloc_ff  <= '0;
         next_ff   <= '0;
         region_ff <= REGION_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            region_ff <= csr_data;
         end
         if (cmd.sub_used) begin
            used_ff <= used_ff - size_rd;
         end
         if (cmd.resize || cmd.commit_realloc) begin
            used_ff <= new_used_c;
         end
         if (cmd.commit_alloc) begin
            used_ff  <= used_ff + size_ff;
            alloc_ff <= alloc_ff + 32'd1;
            next_ff  <= next_ff + 32'd1;
            pend_ff  <= 1'b1;
         end
         if (cmd.remove) begin
            count_ff <= count_ff - CW'(1);
         end
         if (cmd.insert) begin
            count_ff <= count_ff + CW'(1);
            pend_ff  <= 1'b0;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= mode_type'(req_tuser);
         hid_ff  <= req_tdata[31:0];
         size_ff <= req_tdata[63:32];
         st_ff   <= ST_OK;
         hout_ff <= (mode_type'(req_tuser) == MODE_ALLOC) ? 32'd0 : req_tdata[31:0];
         oout_ff <= '0;
      end
      if (cmd.set_st) begin
         st_ff <= cmd.st;
      end
      if (cmd.commit_alloc) begin
         hout_ff <= next_ff;
      end
      if (cmd.commit_alloc || cmd.commit_realloc) begin
         base_ff <= used_ff;
      end
      if (cmd.load || cmd.ptr_clr) begin
         ptr_ff <= '0;
      end else if (cmd.ptr_idx) begin
         ptr_ff <= idx_ff;
      end else if (cmd.ptr_after_idx) begin
         ptr_ff <= idx_ff + CW'(1);
      end else if (cmd.ptr_inc) begin
         ptr_ff <= ptr_ff + CW'(1);
      end
      if (cmd.take_idx) begin
         idx_ff     <= ptr_ff;
         old_ff     <= size_rd;
         idx_off_ff <= off_rd;
         end_ff     <= off_ext + {1'b0, size_rd};
      end
      if (cmd.oout_rd) begin
         oout_ff <= off_rd;
      end
      if (cmd.oout_idx) begin
         oout_ff <= idx_off_ff;
      end
      if (cmd.insert) begin
         oout_ff <= where_ff;
      end
      if (cmd.cur_clr) begin
         cur_ff <= '0;
      end else if (cmd.cur_hole) begin
         cur_ff <= off_ext + {1'b0, size_rd};
      end else if (cmd.cur_pack) begin
         cur_ff <= cur_ff + {1'b0, size_rd};
      end
      if (cmd.where_cur) begin
         where_ff <= cur_ff[31:0];
      end
      if (cmd.where_base) begin
         where_ff <= base_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < MAX_ENTRIES; j++) begin
         if (cmd.pack_wr && (ptr_ix == IW'(j))) begin
            offs_ff[j] <= cur_ff[31:0];
         end
         if (cmd.resize && (idx_ix == IW'(j))) begin
            sizes_ff[j] <= size_ff;
         end
         if (cmd.remove && (idx_ff <= CW'(j)) && (j + 1 < MAX_ENTRIES)) begin
            ids_ff[j]   <= ids_ff[(j + 1) % MAX_ENTRIES];
            offs_ff[j]  <= offs_ff[(j + 1) % MAX_ENTRIES];
            sizes_ff[j] <= sizes_ff[(j + 1) % MAX_ENTRIES];
         end
         if (cmd.insert) begin
            if (ptr_ff == CW'(j)) begin
               ids_ff[j]   <= hout_ff;
               offs_ff[j]  <= where_ff;
               sizes_ff[j] <= size_ff;
            end else if ((ptr_ff < CW'(j)) && (j > 0)) begin
               ids_ff[j]   <= ids_ff[(j + MAX_ENTRIES - 1) % MAX_ENTRIES];
               offs_ff[j]  <= offs_ff[(j + MAX_ENTRIES - 1) % MAX_ENTRIES];
               sizes_ff[j] <= sizes_ff[(j + MAX_ENTRIES - 1) % MAX_ENTRIES];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff[159:128] <= used_ff;
         rsp_data_ff[191:160] <= free_c;
         rsp_data_ff[223:192] <= alloc_ff;
         rsp_data_ff[231:224] <= 8'(live_c);
         case (cmd.kind)
            KIND_PACK: begin
               rsp_user_ff          <= ST_OK;
               rsp_last_ff          <= 1'b0;
               rsp_data_ff[31:0]    <= id_rd;
               rsp_data_ff[63:32]   <= cur_ff[31:0];
               rsp_data_ff[95:64]   <= off_rd;
               rsp_data_ff[127:96]  <= size_rd;
            end
            KIND_RELOC: begin
               rsp_user_ff          <= ST_OK;
               rsp_last_ff          <= 1'b0;
               rsp_data_ff[31:0]    <= hid_ff;
               rsp_data_ff[63:32]   <= where_ff;
               rsp_data_ff[95:64]   <= off_rd;
               rsp_data_ff[127:96]  <= old_ff;
            end
            default: begin
               rsp_user_ff          <= st_ff;
               rsp_last_ff          <= 1'b1;
               rsp_data_ff[31:0]    <= hout_ff;
               rsp_data_ff[63:32]   <= oout_ff;
               rsp_data_ff[95:64]   <= '0;
               rsp_data_ff[127:96]  <= '0;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== src/first_fit_region_allocator_top.sv =====
// Top level of the first-fit region allocator: controller, datapath and checks.
// Depends on ffra_pkg, ffra_ctrl, ffra_dp and the assertion macro header.
//
//  Channel  Direction  Transfer when             Contents
//  req_     in         req_tvalid & req_tready   mode in tuser, id and size in tdata
//  rsp_     out        rsp_tvalid & rsp_tready   status in tuser, results in tdata, tlast
//  csr_     in         csr_valid & csr_ready     region_size
//
// Requests scan the entry table through its single read port: the id search, hole
// search, compaction and insertion scan each visit the entries in table order. Reset
// clears the counters, totals and controller; table entries are never read until
// written. Each move result and the final result wait in the result register
// until taken, and a stalled result channel holds the controller at that step.
`include "first_fit_region_allocator_top_macros.svh"
module first_fit_region_allocator_top
   import ffra_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [31:0] handle_id, [63:32] request_size
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] mode
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] handle_out, [63:32] offset_out, [95:64] move_source, [127:96] move_length,
   // [159:128] bytes_used, [191:160] bytes_free, [223:192] allocation_count,
   // [228:224] live_entries, [231:229] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [2:0] status
   output logic [2:0]            rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [31:0]           csr_data
);

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       req_fire;
   logic [4:0] rsp_live;

   assign csr_ready = 1'b1;
   assign req_fire  = req_tvalid & req_tready;
   assign rsp_live  = rsp_tdata[228:224];

   ffra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ffra_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `FFRA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_tready, "input when busy")
   `FFRA_ASSERT_NOW(a_live_bound, clock, reset, rsp_tvalid, rsp_live <= 5'(MAX_ENTRIES), "live high")
   `FFRA_ASSERT_NOW(a_move_ok, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tuser == ST_OK, "move err")

endmodule
